FILE: src/first_fit_heap_allocator_core_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FFHA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha: next-cycle check failed");

`endif

FILE: src/ffha_pkg.sv
// Shared types and fixed constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int KIND_W     = 2;
  localparam int REQ_W      = 13;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int OFFSET_W   = 13;
  // Rounded request size: up to 8196 bytes with the default 4-byte header.
  localparam int NEED_W     = 14;
  // Widest slot index over the supported heap sizes.
  localparam int MAX_SLOT_W = 18;
  localparam int QDEPTH     = 2;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'd4096;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATS = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ALLOC,
    OP_FREE,
    OP_STATS
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [NEED_W-1:0]     need;
    logic [MAX_SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic                granted;
    logic [COUNT_W-1:0]  block_count;
    logic [COUNT_W-1:0]  allocated_count;
    logic [OFFSET_W-1:0] frontier_offset;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_CUT  = 3'b100
  } state_t;

endpackage

FILE: src/ffha_front.sv
// Front end: decodes a request into a command for the back end.
module ffha_front
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic [KIND_W-1:0] kind,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] release_address,
  input  logic [ADDR_W-1:0] heap_base,
  output cmd_t              cmd
);

  localparam int FRONT_W = $clog2(HEAP_BYTES + 1);

  logic [NEED_W-1:0]  n_raw;
  logic [NEED_W-1:0]  need;
  logic [ADDR_W:0]    base_w;
  logic [ADDR_W:0]    rel_w;
  logic [ADDR_W:0]    end_w;
  logic               in_range;
  logic [ADDR_W-1:0]  off_full;
  logic [FRONT_W-1:0] off;
  logic [FRONT_W-1:0] hoff;
  logic               free_ok;

  // The size always grows by one to four bytes to the next multiple of four.
  assign n_raw = NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES);
  assign need  = {n_raw[NEED_W-1:2] + (NEED_W-2)'(1), 2'b00};

  assign base_w   = {1'b0, heap_base};
  assign rel_w    = {1'b0, release_address};
  assign end_w    = base_w + (ADDR_W+1)'(HEAP_BYTES);
  assign in_range = (rel_w > base_w) && (rel_w < end_w);
  assign off_full = release_address - heap_base;
  assign off      = off_full[FRONT_W-1:0];
  assign hoff     = off - FRONT_W'(HEADER_BYTES);
  assign free_ok  = in_range && (off >= FRONT_W'(HEADER_BYTES)) && (hoff[1:0] == 2'b00);

  always_comb begin
    cmd      = '0;
    cmd.need = need;
    cmd.slot = MAX_SLOT_W'(hoff >> 2);
    case (kind)
      KIND_ALLOC: cmd.op = OP_ALLOC;
      KIND_FREE:  cmd.op = free_ok ? OP_FREE : OP_NOP;
      KIND_STATS: cmd.op = OP_STATS;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

FILE: src/ffha_cmdq.sv
// Two-entry command queue between the front end and the back end.
module ffha_cmdq
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`include "first_fit_heap_allocator_core_macros.svh"

  `FFHA_ASSERT_NOW(a_no_pop_when_empty, pop, count_r != '0)
  `FFHA_ASSERT_NOW(a_no_push_when_full, count_r == CNT_W'(QDEPTH), !push)

endmodule

FILE: src/ffha_back.sv
// Back end: header memory, chain walker, block cutter and result register.
module ffha_back
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] heap_base,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  localparam int SLOTS   = HEAP_BYTES / 4;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int SZ_W    = $clog2(SLOTS + 1);
  localparam int FRONT_W = $clog2(HEAP_BYTES + 1);
  localparam int SUM_W   = ((FRONT_W > NEED_W) ? FRONT_W : NEED_W) + 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Block size in words and allocated mark, one entry per 4-byte offset.
  logic [SZ_W-1:0] size_mem [SLOTS];
  logic            mark_mem [SLOTS];

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [FRONT_W-1:0] pos_r, pos_nxt;
  logic [FRONT_W-1:0] frontier_r, frontier_nxt;
  logic [CNT_W-1:0]   blocks_r, blocks_nxt;
  logic [CNT_W-1:0]   marked_r, marked_nxt;
  logic [SZ_W-1:0]    size_rd_r;
  logic               mark_rd_r;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  logic [SUM_W-1:0] sz_bytes;
  logic [SUM_W-1:0] next_pos;
  logic [SUM_W-1:0] cut_end;
  logic             past_end;
  logic             fit_here;
  logic             cut_fits;
  logic [IDX_W-1:0] rd_idx;
  logic             size_we;
  logic [IDX_W-1:0] size_waddr;
  logic [SZ_W-1:0]  size_wdata;
  logic             mark_we;
  logic [IDX_W-1:0] mark_waddr;
  logic             mark_wdata;

  assign sz_bytes = SUM_W'({size_rd_r, 2'b00});
  assign next_pos = SUM_W'(pos_r) + sz_bytes;
  assign past_end = (next_pos >= SUM_W'(frontier_r));
  assign fit_here = !mark_rd_r && (sz_bytes >= SUM_W'(cmd_r.need));
  assign cut_end  = SUM_W'(frontier_r) + SUM_W'(cmd_r.need);
  assign cut_fits = (cut_end <= SUM_W'(HEAP_BYTES));

  // While walking, the next header is fetched as soon as this one's size is known.
  assign rd_idx = (state_r == ST_WALK) ? next_pos[IDX_W+1:2] : '0;

  assign cmd_take  = (state_r == ST_IDLE) && cmd_valid && (!out_valid_r || !res_stall);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    frontier_nxt  = frontier_r;
    blocks_nxt    = blocks_r;
    marked_nxt    = marked_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && res_stall;
    size_we       = 1'b0;
    size_waddr    = frontier_r[IDX_W+1:2];
    size_wdata    = SZ_W'(cmd_r.need >> 2);
    mark_we       = 1'b0;
    mark_waddr    = pos_r[IDX_W+1:2];
    mark_wdata    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (cmd_take) begin
          cmd_nxt    = cmd;
          pos_nxt    = '0;
          blocks_nxt = '0;
          marked_nxt = '0;
          case (cmd.op)
            OP_ALLOC: begin
              state_nxt = (frontier_r == '0) ? ST_CUT : ST_WALK;
            end
            OP_STATS: begin
              if (frontier_r == '0) begin
                res_nxt                 = '0;
                res_nxt.frontier_offset = OFFSET_W'(frontier_r);
                out_valid_nxt           = 1'b1;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            OP_FREE: begin
              mark_we       = 1'b1;
              mark_waddr    = cmd.slot[IDX_W-1:0];
              mark_wdata    = 1'b0;
              res_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              res_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (cmd_r.op == OP_ALLOC) begin
          if (fit_here) begin
            mark_we                 = 1'b1;
            res_nxt                 = '0;
            res_nxt.granted_address = heap_base + ADDR_W'(pos_r) + ADDR_W'(HEADER_BYTES);
            res_nxt.granted         = 1'b1;
            out_valid_nxt           = 1'b1;
            state_nxt               = ST_IDLE;
          end else if (past_end) begin
            state_nxt = ST_CUT;
          end else begin
            pos_nxt = next_pos[FRONT_W-1:0];
          end
        end else begin
          blocks_nxt = blocks_r + CNT_W'(1);
          marked_nxt = marked_r + CNT_W'(mark_rd_r);
          if (past_end) begin
            res_nxt                 = '0;
            res_nxt.block_count     = COUNT_W'(blocks_nxt);
            res_nxt.allocated_count = COUNT_W'(marked_nxt);
            res_nxt.frontier_offset = OFFSET_W'(frontier_r);
            out_valid_nxt           = 1'b1;
            state_nxt               = ST_IDLE;
          end else begin
            pos_nxt = next_pos[FRONT_W-1:0];
          end
        end
      end

      ST_CUT: begin
        res_nxt = '0;
        if (cut_fits) begin
          size_we                 = 1'b1;
          mark_we                 = 1'b1;
          mark_waddr              = frontier_r[IDX_W+1:2];
          frontier_nxt            = FRONT_W'(cut_end);
          res_nxt.granted_address = heap_base + ADDR_W'(frontier_r) + ADDR_W'(HEADER_BYTES);
          res_nxt.granted         = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frontier_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frontier_r  <= frontier_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    blocks_r <= blocks_nxt;
    marked_r <= marked_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    size_rd_r <= size_mem[rd_idx];
    mark_rd_r <= mark_mem[rd_idx];
  end

`include "first_fit_heap_allocator_core_macros.svh"

  `FFHA_ASSERT_NOW(a_walk_inside_chain, state_r == ST_WALK, pos_r < frontier_r)
  `FFHA_ASSERT_NOW(a_walk_header_nonzero, state_r == ST_WALK, size_rd_r != '0)
  `FFHA_ASSERT_NEXT(a_frontier_moves_in_cut, state_r != ST_CUT, $stable(frontier_r))

endmodule

FILE: src/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: configuration register and module wiring.
//
// Usage: requests enter on the in_ channel (in_kind 0 allocate, 1 free, 2 statistics) and
// every request yields exactly one result transaction on the out_ channel, in order.
// A transaction moves at a rising edge with valid high and stall low on that channel.
// cfg_we writes cfg_wdata into the heap base address; write it only while the block is idle.
// Accepted requests go into a two-entry command queue, so in_stall rises only when it is full.
// A free or an unused kind is answered straight from the back end's idle state. A statistics
// request walks every block header, and an allocate walks the headers until the first free
// block that is large enough, or cuts a new block at the frontier when none is. The walk reads
// one header per cycle from the single read port of the header memory. The result then shows
// on the output register.
// While a valid result is stalled it holds and the back end does not start another command,
// but the queue still accepts up to two requests.
// Reset (rst_n low, synchronous) empties the queue and the result register, sets the frontier
// to zero and the heap base to 4096. The header memory is not cleared: the walk only visits
// headers written since reset.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [REQ_W-1:0]    in_request_bytes,
  input  logic [ADDR_W-1:0]   in_release_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_granted_address,
  output logic                out_granted,
  output logic [COUNT_W-1:0]  out_block_count,
  output logic [COUNT_W-1:0]  out_allocated_count,
  output logic [OFFSET_W-1:0] out_frontier_offset
);

  logic [ADDR_W-1:0] heap_base_r;
  cmd_t              front_cmd;
  cmd_t              head_cmd;
  logic              q_full;
  logic              q_not_empty;
  logic              q_push;
  logic              q_pop;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= HEAP_BASE_RESET;
    end else if (cfg_we) begin
      heap_base_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  ffha_front #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .kind            (in_kind),
    .request_bytes   (in_request_bytes),
    .release_address (in_release_address),
    .heap_base       (heap_base_r),
    .cmd             (front_cmd)
  );

  ffha_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  ffha_back #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .heap_base (heap_base_r),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_take  (q_pop),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign out_granted_address = res.granted_address;
  assign out_granted         = res.granted;
  assign out_block_count     = res.block_count;
  assign out_allocated_count = res.allocated_count;
  assign out_frontier_offset = res.frontier_offset;

endmodule
